FILE: sv/kmdt_pkg.sv
// Shared types and reset constants for the keyboard/mouse debounce and toggle block.
`default_nettype none

package kmdt_pkg;

   localparam int unsigned NumDeb     = 5;
   localparam int unsigned KeyWidth   = 16;
   localparam int unsigned TimeWidth  = 32;
   localparam int unsigned CodeWidth  = 2;
   localparam int unsigned BitWidth   = 4;
   localparam int unsigned DebWidth   = 10;
   localparam int unsigned HoldWidth  = 14;
   localparam int unsigned CsrIdxWidth  = 3;
   localparam int unsigned CsrDataWidth = 14;

   // Lane order inside the five-bit debounce vector
   localparam int unsigned LaneLauncher = 0;
   localparam int unsigned LaneShot     = 1;
   localparam int unsigned LaneBypass   = 2;
   localparam int unsigned LaneLeft     = 3;
   localparam int unsigned LaneRight    = 4;

   localparam logic [CodeWidth-1:0] MiddleCodeRst   = 2'd3;
   localparam logic [BitWidth-1:0]  LauncherBitRst  = 4'd8;
   localparam logic [BitWidth-1:0]  ShotBitRst      = 4'd10;
   localparam logic [BitWidth-1:0]  BypassBitRst    = 4'd14;
   localparam logic [DebWidth-1:0]  DebounceRst     = 10'd20;
   localparam logic [HoldWidth-1:0] VisionHoldRst   = 14'd300;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_MIDDLE_CODE  = 3'd0,
      CSR_LAUNCHER_BIT = 3'd1,
      CSR_SHOT_BIT     = 3'd2,
      CSR_BYPASS_BIT   = 3'd3,
      CSR_DEBOUNCE_MS  = 3'd4,
      CSR_VISION_HOLD  = 3'd5
   } csr_index_type;

   // Per-sample control handed to every debounce lane
   typedef struct packed {
      logic step;      // a sample is being applied this cycle
      logic keymouse;  // sample selects keyboard/mouse (else clear lanes)
   } deb_ctl_type;

endpackage

`default_nettype wire

FILE: sv/keymouse_debounce_toggle_modes.sv
// Top level: keyboard/mouse sample debounce, toggle keys and right-button hold detection.
`default_nettype none

// Channel  | Dir | Handshake               | Payload
// ---------+-----+-------------------------+------------------------------------------
// req_     | in  | req_valid / req_stall   | switch codes, key mask, buttons, now_ms
// rsp_     | out | rsp_valid / rsp_stall   | source, held keys, toggles, vision, buttons
// csr_     | in  | csr_wr_en               | csr_index, csr_wr_data (six registers)
//
// One beat per cycle sustained unless rsp_ stalls; a sample passes the input register, then the state/result registers.
// The rate is set by the single state-update pass between the input register and
// the state/result registers, which are one and the same set of flops.
// Synchronous active-high reset clears all state (not the input payload); no clearing pass is needed.
// A stalled rsp_ holds its beat; the input register still takes one more beat,
// after which req_stall rises until the result side drains.

module keymouse_debounce_toggle_modes (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                csr_wr_en,
   input  wire logic [kmdt_pkg::CsrIdxWidth-1:0]    csr_index,
   input  wire logic [kmdt_pkg::CsrDataWidth-1:0]   csr_wr_data,

   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [kmdt_pkg::CodeWidth-1:0]      req_switch_one,
   input  wire logic [kmdt_pkg::CodeWidth-1:0]      req_switch_two,
   input  wire logic [kmdt_pkg::KeyWidth-1:0]       req_key_mask,
   input  wire logic                                req_mouse_left_raw,
   input  wire logic                                req_mouse_right_raw,
   input  wire logic [kmdt_pkg::TimeWidth-1:0]      req_now_ms,

   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_keymouse_active,
   output logic [kmdt_pkg::KeyWidth-1:0]            rsp_held_key_mask,
   output logic                                     rsp_launcher_on,
   output logic                                     rsp_single_shot,
   output logic                                     rsp_heat_bypass,
   output logic                                     rsp_vision_on,
   output logic                                     rsp_left_pressed,
   output logic                                     rsp_right_pressed
);
   import kmdt_pkg::*;

   // ---------------- configuration registers ----------------
   logic [CodeWidth-1:0] middle_code_ff;
   logic [BitWidth-1:0]  launcher_bit_ff;
   logic [BitWidth-1:0]  shot_bit_ff;
   logic [BitWidth-1:0]  bypass_bit_ff;
   logic [DebWidth-1:0]  debounce_ff;
   logic [HoldWidth-1:0] vision_hold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         middle_code_ff  <= MiddleCodeRst;
         launcher_bit_ff <= LauncherBitRst;
         shot_bit_ff     <= ShotBitRst;
         bypass_bit_ff   <= BypassBitRst;
         debounce_ff     <= DebounceRst;
         vision_hold_ff  <= VisionHoldRst;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_MIDDLE_CODE:  middle_code_ff  <= csr_wr_data[CodeWidth-1:0];
            CSR_LAUNCHER_BIT: launcher_bit_ff <= csr_wr_data[BitWidth-1:0];
            CSR_SHOT_BIT:     shot_bit_ff     <= csr_wr_data[BitWidth-1:0];
            CSR_BYPASS_BIT:   bypass_bit_ff   <= csr_wr_data[BitWidth-1:0];
            CSR_DEBOUNCE_MS:  debounce_ff     <= csr_wr_data[DebWidth-1:0];
            CSR_VISION_HOLD:  vision_hold_ff  <= csr_wr_data[HoldWidth-1:0];
            default: ;  // indexes past the list write nothing
         endcase
      end
   end

   // ---------------- handshake / pipeline control ----------------
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_busy;   // result beat waiting and stalled
   logic req_take;
   logic step;       // apply the registered sample to the state this cycle

   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign step      = s1_valid_ff && !out_busy;
   assign req_stall = s1_valid_ff && out_busy;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (step) begin
         s1_valid_in = 1'b0;
      end
   end

   // Load a fresh result on a step; drop the current one once taken
   assign rsp_valid_in = step || out_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------- input register (payload, no reset) ----------------
   logic [CodeWidth-1:0] sw_one_ff;
   logic [CodeWidth-1:0] sw_two_ff;
   logic [KeyWidth-1:0]  keys_ff;
   logic                 left_ff;
   logic                 right_ff;
   logic [TimeWidth-1:0] now_ff;

   always_ff @(posedge clock) begin
      if (req_take) begin
         sw_one_ff <= req_switch_one;
         sw_two_ff <= req_switch_two;
         keys_ff   <= req_key_mask;
         left_ff   <= req_mouse_left_raw;
         right_ff  <= req_mouse_right_raw;
         now_ff    <= req_now_ms;
      end
   end

   // ---------------- debounce lanes ----------------
   logic              keymouse;
   logic [NumDeb-1:0] raw_bits;
   logic [NumDeb-1:0] conf_next;
   logic [NumDeb-1:0] conf_bits;
   deb_ctl_type       deb_ctl;

   // Both switches at the middle code select keyboard/mouse input
   assign keymouse = (sw_one_ff == middle_code_ff) && (sw_two_ff == middle_code_ff);

   assign raw_bits[LaneLauncher] = keys_ff[launcher_bit_ff];
   assign raw_bits[LaneShot]     = keys_ff[shot_bit_ff];
   assign raw_bits[LaneBypass]   = keys_ff[bypass_bit_ff];
   assign raw_bits[LaneLeft]     = left_ff;
   assign raw_bits[LaneRight]    = right_ff;

   assign deb_ctl.step     = step;
   assign deb_ctl.keymouse = keymouse;

   for (genvar g = 0; g < NumDeb; g++) begin : g_lane
      kmdt_deb_lane u_lane (
         .clock          (clock),
         .reset          (reset),
         .ctl            (deb_ctl),
         .raw            (raw_bits[g]),
         .now_ms         (now_ff),
         .debounce_ms    (debounce_ff),
         .confirmed_next (conf_next[g]),
         .confirmed      (conf_bits[g])
      );
   end

   // ---------------- toggles, hold and source state ----------------
   logic                 source_ff, source_in;
   logic [KeyWidth-1:0]  saved_keys_ff, saved_keys_in;
   logic [2:0]           last_keys_ff, last_keys_in;
   logic                 launcher_ff, launcher_in;
   logic                 single_ff, single_in;
   logic                 bypass_ff, bypass_in;
   logic [TimeWidth-1:0] hold_start_ff, hold_start_in;
   logic                 vision_ff, vision_in;

   logic [2:0]           key_edges;
   logic                 launcher_flip;
   logic                 hold_idle;
   logic [TimeWidth-1:0] hold_elapsed;

   assign key_edges     = conf_next[LaneBypass:LaneLauncher] & ~last_keys_ff;
   assign launcher_flip = launcher_ff ^ key_edges[LaneLauncher];

   // Zero start means not started: the hold begins now, so elapsed is zero
   assign hold_idle    = hold_start_ff == '0;
   assign hold_elapsed = hold_idle ? '0 : (now_ff - hold_start_ff);

   always_comb begin
      source_in     = source_ff;
      saved_keys_in = saved_keys_ff;
      last_keys_in  = last_keys_ff;
      launcher_in   = launcher_ff;
      single_in     = single_ff;
      bypass_in     = bypass_ff;
      hold_start_in = hold_start_ff;
      vision_in     = vision_ff;
      if (step) begin
         if (keymouse) begin
            source_in     = 1'b1;
            saved_keys_in = keys_ff;
            last_keys_in  = conf_next[LaneBypass:LaneLauncher];
            launcher_in   = launcher_flip;
            // Launcher switching on forces single shot; the shot key acts only with launcher on
            if (key_edges[LaneLauncher] && launcher_flip) begin
               single_in = 1'b1;
            end
            if (launcher_flip && key_edges[LaneShot]) begin
               single_in = ~single_in;
            end
            bypass_in = bypass_ff ^ key_edges[LaneBypass];
            if (conf_next[LaneRight]) begin
               hold_start_in = hold_idle ? now_ff : hold_start_ff;
               vision_in     = hold_elapsed >= {{(TimeWidth-HoldWidth){1'b0}}, vision_hold_ff};
            end else begin
               hold_start_in = '0;
               vision_in     = 1'b0;
            end
         end else begin
            // Remote source: drop all keyboard/mouse state
            source_in     = 1'b0;
            saved_keys_in = '0;
            last_keys_in  = '0;
            launcher_in   = 1'b0;
            single_in     = 1'b1;
            bypass_in     = 1'b0;
            hold_start_in = '0;
            vision_in     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         source_ff     <= 1'b0;
         saved_keys_ff <= '0;
         last_keys_ff  <= '0;
         launcher_ff   <= 1'b0;
         single_ff     <= 1'b1;
         bypass_ff     <= 1'b0;
         hold_start_ff <= '0;
         vision_ff     <= 1'b0;
      end else begin
         source_ff     <= source_in;
         saved_keys_ff <= saved_keys_in;
         last_keys_ff  <= last_keys_in;
         launcher_ff   <= launcher_in;
         single_ff     <= single_in;
         bypass_ff     <= bypass_in;
         hold_start_ff <= hold_start_in;
         vision_ff     <= vision_in;
      end
   end

   // State changes only on a step, so the state flops double as the result register
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_keymouse_active = source_ff;
   assign rsp_held_key_mask   = saved_keys_ff;
   assign rsp_launcher_on     = launcher_ff;
   assign rsp_single_shot     = single_ff;
   assign rsp_heat_bypass     = bypass_ff;
   assign rsp_vision_on       = vision_ff;
   assign rsp_left_pressed    = conf_bits[LaneLeft];
   assign rsp_right_pressed   = conf_bits[LaneRight];

   // ---------------- assertions ----------------
   a_remote_beat_cleared: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_keymouse_active) |->
         (rsp_held_key_mask == '0) && !rsp_launcher_on && rsp_single_shot
         && !rsp_heat_bypass && !rsp_vision_on && !rsp_left_pressed && !rsp_right_pressed
   ) else $error("remote result carries keyboard/mouse state");

   a_vision_needs_right: assert property (
      @(posedge clock) disable iff (reset)
      vision_ff |-> conf_bits[LaneRight]
   ) else $error("vision on without debounced right button");

   a_pending_sample_kept: assert property (
      @(posedge clock) disable iff (reset)
      (s1_valid_ff && out_busy) |=> s1_valid_ff
   ) else $error("registered sample lost while result side stalled");

   a_state_only_on_step: assert property (
      @(posedge clock) disable iff (reset)
      !step |=> $stable(launcher_ff) && $stable(single_ff) && $stable(saved_keys_ff)
   ) else $error("toggle state changed without a sample");

endmodule

`default_nettype wire

FILE: sv/kmdt_deb_lane.sv
// One debounce lane: tracks the last raw level, its stable start time and the confirmed level.
`default_nettype none

module kmdt_deb_lane (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire kmdt_pkg::deb_ctl_type            ctl,
   input  wire logic                             raw,
   input  wire logic [kmdt_pkg::TimeWidth-1:0]   now_ms,
   input  wire logic [kmdt_pkg::DebWidth-1:0]    debounce_ms,
   output logic                                  confirmed_next,
   output logic                                  confirmed
);
   import kmdt_pkg::*;

   logic [TimeWidth-1:0] start_ff;
   logic [TimeWidth-1:0] start_in;
   logic                 last_raw_ff;
   logic                 last_raw_in;
   logic                 confirmed_ff;
   logic                 confirmed_in;
   logic                 changed;
   logic [TimeWidth-1:0] elapsed;
   logic                 settled;

   // A change restarts the window, so the elapsed time reads as zero
   assign changed = raw != last_raw_ff;
   assign elapsed = changed ? '0 : (now_ms - start_ff);
   assign settled = elapsed >= {{(TimeWidth-DebWidth){1'b0}}, debounce_ms};

   assign confirmed_next = settled ? raw : confirmed_ff;
   assign confirmed      = confirmed_ff;

   always_comb begin
      start_in     = start_ff;
      last_raw_in  = last_raw_ff;
      confirmed_in = confirmed_ff;
      if (ctl.step) begin
         if (ctl.keymouse) begin
            start_in     = changed ? now_ms : start_ff;
            last_raw_in  = raw;
            confirmed_in = confirmed_next;
         end else begin
            start_in     = now_ms;
            last_raw_in  = 1'b0;
            confirmed_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= '0;
         last_raw_ff  <= 1'b0;
         confirmed_ff <= 1'b0;
      end else begin
         start_ff     <= start_in;
         last_raw_ff  <= last_raw_in;
         confirmed_ff <= confirmed_in;
      end
   end

   a_confirmed_holds_without_step: assert property (
      @(posedge clock) disable iff (reset)
      !ctl.step |=> $stable(confirmed_ff)
   ) else $error("debounce lane changed without a sample");

endmodule

`default_nettype wire

FILE: sim/keymouse_debounce_toggle_modes_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the keyboard/mouse debounce, toggle and hold block.
module keymouse_debounce_toggle_modes_tb;
   import kmdt_pkg::*;

   localparam int unsigned CycleLimit     = 200000;
   localparam int unsigned IdlePercent    = 29;
   localparam int unsigned LongHoldCycles = 80;
   localparam int unsigned PhaseItems     = 65;
   localparam int unsigned NumPhases      = 6;
   localparam int unsigned QuietPhase     = 4;

   // One input beat
   typedef struct packed {
      logic [CodeWidth-1:0] switch_one;
      logic [CodeWidth-1:0] switch_two;
      logic [KeyWidth-1:0]  key_mask;
      logic                 left_raw;
      logic                 right_raw;
      logic [TimeWidth-1:0] now_ms;
   } km_sample_type;

   // One result beat
   typedef struct packed {
      logic                active;
      logic [KeyWidth-1:0] held_keys;
      logic                launcher;
      logic                single_shot;
      logic                bypass;
      logic                vision;
      logic                left;
      logic                right;
   } km_report_type;

   typedef struct packed {
      logic [CodeWidth-1:0] middle_code;
      logic [BitWidth-1:0]  launcher_bit;
      logic [BitWidth-1:0]  shot_bit;
      logic [BitWidth-1:0]  bypass_bit;
      logic [DebWidth-1:0]  debounce_ms;
      logic [HoldWidth-1:0] vision_hold_ms;
   } km_setting_type;

   // Directed stimulus row: a typed report is compared as is, otherwise the
   // predictor supplies the expectation
   typedef struct packed {
      km_sample_type sample;
      logic          typed;
      km_report_type want;
   } km_row_type;

   // Remote source: everything back to its cleared value, single-shot set
   localparam km_report_type Cleared = '{1'b0, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
   // Keyboard source, every key down but nothing debounced yet
   localparam km_report_type FreshKeys = '{1'b1, 16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
   localparam km_report_type Predicted = '0;

   localparam km_setting_type DefaultSetting = '{MiddleCodeRst, LauncherBitRst, ShotBitRst,
                                                 BypassBitRst, DebounceRst, VisionHoldRst};
   // Middle code zero, all three keys on one bit, zero debounce and hold
   localparam km_setting_type EdgeSetting = '{2'd0, 4'd5, 4'd5, 4'd5, 10'd0, 14'd0};

   // Default setting: wrap-safe debounce, hold, toggles, hold started at tick zero
   km_row_type default_rows [19] = '{
      '{'{2'd0, 2'd0, 16'hFFFF, 1'b1, 1'b1, 32'd100},      1'b1, Cleared},
      '{'{2'd3, 2'd2, 16'h0000, 1'b0, 1'b0, 32'hFFFF_FFFF}, 1'b1, Cleared},
      '{'{2'd3, 2'd3, 16'hFFFF, 1'b1, 1'b1, 32'hFFFF_FFF0}, 1'b1, FreshKeys},
      '{'{2'd3, 2'd3, 16'hFFFF, 1'b1, 1'b1, 32'h0000_0004}, 1'b0, Predicted},
      '{'{2'd3, 2'd3, 16'hFFFF, 1'b1, 1'b1, 32'h0000_012F}, 1'b0, Predicted},
      '{'{2'd3, 2'd3, 16'hFFFF, 1'b1, 1'b1, 32'h0000_0130}, 1'b0, Predicted},
      '{'{2'd3, 2'd3, 16'hFFFF, 1'b1, 1'b0, 32'h0000_0190}, 1'b0, Predicted},
      '{'{2'd3, 2'd3, 16'h0000, 1'b0, 1'b0, 32'h0000_01F4}, 1'b0, Predicted},
      '{'{2'd3, 2'd3, 16'h0000, 1'b0, 1'b0, 32'h0000_0208}, 1'b0, Predicted},
      '{'{2'd3, 2'd3, 16'h0100, 1'b0, 1'b0, 32'h0000_0210}, 1'b0, Predicted},
      '{'{2'd3, 2'd3, 16'h0100, 1'b0, 1'b0, 32'h0000_0230}, 1'b0, Predicted},
      '{'{2'd3, 2'd3, 16'h0400, 1'b0, 1'b0, 32'h0000_0240}, 1'b0, Predicted},
      '{'{2'd3, 2'd3, 16'h0400, 1'b0, 1'b0, 32'h0000_0260}, 1'b0, Predicted},
      '{'{2'd1, 2'd3, 16'h0000, 1'b0, 1'b0, 32'hFFFF_FFEC}, 1'b1, Cleared},
      '{'{2'd3, 2'd3, 16'h0000, 1'b0, 1'b1, 32'hFFFF_FFEC}, 1'b0, Predicted},
      '{'{2'd3, 2'd3, 16'h0000, 1'b0, 1'b1, 32'h0000_0000}, 1'b0, Predicted},
      '{'{2'd3, 2'd3, 16'h0000, 1'b0, 1'b1, 32'h0000_0005}, 1'b0, Predicted},
      '{'{2'd3, 2'd3, 16'h0000, 1'b0, 1'b1, 32'h0000_012C}, 1'b0, Predicted},
      '{'{2'd3, 2'd3, 16'h0000, 1'b0, 1'b1, 32'h0000_0131}, 1'b0, Predicted}
   };

   // Edge setting: instant confirm and vision, shared key bit, middle code zero
   km_row_type edge_rows [7] = '{
      '{'{2'd0, 2'd0, 16'h0020, 1'b1, 1'b0, 32'd1000},      1'b0, Predicted},
      '{'{2'd0, 2'd0, 16'h0000, 1'b0, 1'b1, 32'd1001},      1'b0, Predicted},
      '{'{2'd0, 2'd0, 16'h0020, 1'b0, 1'b1, 32'd1002},      1'b0, Predicted},
      '{'{2'd3, 2'd3, 16'hFFFF, 1'b1, 1'b1, 32'd7},         1'b1, Cleared},
      '{'{2'd0, 2'd1, 16'h0000, 1'b0, 1'b0, 32'd8},         1'b1, Cleared},
      '{'{2'd0, 2'd0, 16'hFFDF, 1'b0, 1'b1, 32'h0000_0000}, 1'b0, Predicted},
      '{'{2'd0, 2'd0, 16'hFFFF, 1'b1, 1'b1, 32'h0000_0000}, 1'b0, Predicted}
   };

   km_setting_type phase_settings [NumPhases] = '{
      DefaultSetting,
      '{2'd1, 4'd0, 4'd15, 4'd7, 10'd0, 14'd0},
      '{2'd2, 4'd15, 4'd15, 4'd0, 10'd1000, 14'd10000},
      DefaultSetting,                                   // replaced by a random one
      '{2'd3, 4'd3, 4'd9, 4'd12, 10'd1, 14'd1},
      DefaultSetting                                    // replaced by a random one
   };

   // Clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Block ports
   logic                    csr_wr_en   = 1'b0;
   logic [CsrIdxWidth-1:0]  csr_index   = '0;
   logic [CsrDataWidth-1:0] csr_wr_data = '0;

   logic                    req_valid           = 1'b0;
   logic                    req_stall;
   logic [CodeWidth-1:0]    req_switch_one      = '0;
   logic [CodeWidth-1:0]    req_switch_two      = '0;
   logic [KeyWidth-1:0]     req_key_mask        = '0;
   logic                    req_mouse_left_raw  = 1'b0;
   logic                    req_mouse_right_raw = 1'b0;
   logic [TimeWidth-1:0]    req_now_ms          = '0;

   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_keymouse_active;
   logic [KeyWidth-1:0]     rsp_held_key_mask;
   logic                    rsp_launcher_on;
   logic                    rsp_single_shot;
   logic                    rsp_heat_bypass;
   logic                    rsp_vision_on;
   logic                    rsp_left_pressed;
   logic                    rsp_right_pressed;

   keymouse_debounce_toggle_modes u_top (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_switch_one      (req_switch_one),
      .req_switch_two      (req_switch_two),
      .req_key_mask        (req_key_mask),
      .req_mouse_left_raw  (req_mouse_left_raw),
      .req_mouse_right_raw (req_mouse_right_raw),
      .req_now_ms          (req_now_ms),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_keymouse_active (rsp_keymouse_active),
      .rsp_held_key_mask   (rsp_held_key_mask),
      .rsp_launcher_on     (rsp_launcher_on),
      .rsp_single_shot     (rsp_single_shot),
      .rsp_heat_bypass     (rsp_heat_bypass),
      .rsp_vision_on       (rsp_vision_on),
      .rsp_left_pressed    (rsp_left_pressed),
      .rsp_right_pressed   (rsp_right_pressed)
   );

   // ------------------------------------------------------------------
   // Predictor: shadow of the block's registers and its input tracking
   // ------------------------------------------------------------------
   km_setting_type       tracked_setting;
   logic [NumDeb-1:0]    track_last_raw;
   logic [TimeWidth-1:0] track_stable_since [NumDeb];
   logic [NumDeb-1:0]    track_confirmed;
   logic [2:0]           track_last_keys;
   logic                 track_launcher;
   logic                 track_single_shot;
   logic                 track_bypass;
   logic [TimeWidth-1:0] track_hold_start;   // zero reads as "hold not started"
   logic                 track_vision;
   logic [KeyWidth-1:0]  track_keys;
   logic                 track_source;

   // Drop all keyboard/mouse state; every lane restarts its stable time at now
   function automatic void clear_tracking(input logic [TimeWidth-1:0] now);
      for (int i = 0; i < NumDeb; i++) track_stable_since[i] = now;
      track_last_raw    = '0;
      track_confirmed   = '0;
      track_last_keys   = '0;
      track_launcher    = 1'b0;
      track_single_shot = 1'b1;
      track_bypass      = 1'b0;
      track_hold_start  = '0;
      track_vision      = 1'b0;
      track_keys        = '0;
   endfunction

   function automatic km_report_type predict_report(input km_sample_type s);
      logic [NumDeb-1:0]    raw;
      logic [2:0]           rise;
      logic [TimeWidth-1:0] age;
      if (s.switch_one == tracked_setting.middle_code &&
          s.switch_two == tracked_setting.middle_code) begin
         track_source = 1'b1;
         track_keys   = s.key_mask;
         raw[LaneLauncher] = s.key_mask[tracked_setting.launcher_bit];
         raw[LaneShot]     = s.key_mask[tracked_setting.shot_bit];
         raw[LaneBypass]   = s.key_mask[tracked_setting.bypass_bit];
         raw[LaneLeft]     = s.left_raw;
         raw[LaneRight]    = s.right_raw;
         // Restart a lane on any raw change; confirm once it has aged enough
         for (int i = 0; i < NumDeb; i++) begin
            if (raw[i] != track_last_raw[i]) track_stable_since[i] = s.now_ms;
            age = s.now_ms - track_stable_since[i];
            if (age >= TimeWidth'(tracked_setting.debounce_ms)) track_confirmed[i] = raw[i];
         end
         track_last_raw = raw;
         rise = track_confirmed[2:0] & ~track_last_keys;
         track_last_keys = track_confirmed[2:0];
         // Launcher turning on forces single-shot before the shot key is seen
         if (rise[LaneLauncher]) begin
            track_launcher = ~track_launcher;
            if (track_launcher) track_single_shot = 1'b1;
         end
         if (track_launcher && rise[LaneShot]) track_single_shot = ~track_single_shot;
         if (rise[LaneBypass]) track_bypass = ~track_bypass;
         if (track_confirmed[LaneRight]) begin
            if (track_hold_start == '0) track_hold_start = s.now_ms;
            age = s.now_ms - track_hold_start;
            track_vision = (age >= TimeWidth'(tracked_setting.vision_hold_ms));
         end else begin
            track_hold_start = '0;
            track_vision     = 1'b0;
         end
      end else begin
         track_source = 1'b0;
         clear_tracking(s.now_ms);
      end
      return '{track_source, track_keys, track_launcher, track_single_shot, track_bypass,
               track_vision, track_confirmed[LaneLeft], track_confirmed[LaneRight]};
   endfunction

   // ------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------
   km_report_type awaited_reports [$];
   logic       quiet_phase = 1'b0;   // no idling on either side while set
   int unsigned mismatch_count = 0;

   logic [KeyWidth-1:0]  stim_keys = '0;
   logic                 stim_left = 1'b0;
   logic                 stim_right = 1'b0;
   logic [TimeWidth-1:0] stim_tick = '0;

   // Offer one beat, hold it until taken, then record what it must produce
   task automatic send_sample(input km_sample_type s, input logic typed,
                              input km_report_type want);
      km_report_type expected;
      while (!quiet_phase && $urandom_range(99) < IdlePercent) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_switch_one      <= s.switch_one;
      req_switch_two      <= s.switch_two;
      req_key_mask        <= s.key_mask;
      req_mouse_left_raw  <= s.left_raw;
      req_mouse_right_raw <= s.right_raw;
      req_now_ms          <= s.now_ms;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // Advance the predictor even when the row carries its own expectation
      expected = predict_report(s);
      awaited_reports.push_back(typed ? want : expected);
   endtask

   // Drop valid and let the block drain before touching its registers
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (awaited_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write all six registers back to back, then mirror them in the predictor
   task automatic apply_setting(input km_setting_type set);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_MIDDLE_CODE;
      csr_wr_data <= CsrDataWidth'(set.middle_code);
      @(posedge clock);
      csr_index   <= CSR_LAUNCHER_BIT;
      csr_wr_data <= CsrDataWidth'(set.launcher_bit);
      @(posedge clock);
      csr_index   <= CSR_SHOT_BIT;
      csr_wr_data <= CsrDataWidth'(set.shot_bit);
      @(posedge clock);
      csr_index   <= CSR_BYPASS_BIT;
      csr_wr_data <= CsrDataWidth'(set.bypass_bit);
      @(posedge clock);
      csr_index   <= CSR_DEBOUNCE_MS;
      csr_wr_data <= CsrDataWidth'(set.debounce_ms);
      @(posedge clock);
      csr_index   <= CSR_VISION_HOLD;
      csr_wr_data <= CsrDataWidth'(set.vision_hold_ms);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      tracked_setting = set;
   endtask

   // Mostly keyboard/mouse samples whose inputs stay put long enough to
   // confirm; the rest are remote samples, key noise and wild time jumps
   task automatic run_random_phase(input int unsigned count);
      km_sample_type s;
      int unsigned pick;
      int unsigned deb;
      int unsigned hold;
      deb  = tracked_setting.debounce_ms;
      hold = tracked_setting.vision_hold_ms;
      for (int unsigned n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 25) begin
            case ($urandom_range(5))
               0:       stim_keys[tracked_setting.launcher_bit] ^= 1'b1;
               1:       stim_keys[tracked_setting.shot_bit]     ^= 1'b1;
               2:       stim_keys[tracked_setting.bypass_bit]   ^= 1'b1;
               3:       stim_left  = ~stim_left;
               4:       stim_right = ~stim_right;
               default: stim_keys[$urandom_range(15)] ^= 1'b1;
            endcase
         end else if (pick < 30) begin
            stim_keys = KeyWidth'($urandom());
         end
         pick = $urandom_range(99);
         if (pick < 70) begin
            stim_tick += $urandom_range(deb / 3 + 2, 0);
         end else if (pick < 90) begin
            stim_tick += $urandom_range(deb + hold / 4 + 10, deb);
         end else if (pick >= 97) begin
            stim_tick = $urandom();
         end
         if ($urandom_range(99) < 95) begin
            s.switch_one = tracked_setting.middle_code;
            s.switch_two = tracked_setting.middle_code;
         end else begin
            s.switch_one = CodeWidth'($urandom_range(3));
            s.switch_two = CodeWidth'($urandom_range(3));
         end
         s.key_mask  = stim_keys;
         s.left_raw  = stim_left;
         s.right_raw = stim_right;
         s.now_ms    = stim_tick;
         send_sample(s, 1'b0, Predicted);
      end
   endtask

   // ------------------------------------------------------------------
   // Receiver side: check every result beat, stall at random, and twice
   // hold off long enough for the block to back up into req_stall
   // ------------------------------------------------------------------
   int unsigned reports_seen = 0;
   int unsigned hold_left    = 0;

   task automatic check_field(input string name, input logic [KeyWidth-1:0] want,
                              input logic [KeyWidth-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : result_side
      km_report_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_reports.size() == 0) begin
               $display("%0t: result beat with nothing expected", $realtime);
               mismatch_count++;
            end else begin
               want = awaited_reports.pop_front();
               check_field("keymouse_active", KeyWidth'(want.active),
                           KeyWidth'(rsp_keymouse_active));
               check_field("held_key_mask", want.held_keys, rsp_held_key_mask);
               check_field("launcher_on", KeyWidth'(want.launcher), KeyWidth'(rsp_launcher_on));
               check_field("single_shot", KeyWidth'(want.single_shot),
                           KeyWidth'(rsp_single_shot));
               check_field("heat_bypass", KeyWidth'(want.bypass), KeyWidth'(rsp_heat_bypass));
               check_field("vision_on", KeyWidth'(want.vision), KeyWidth'(rsp_vision_on));
               check_field("left_pressed", KeyWidth'(want.left), KeyWidth'(rsp_left_pressed));
               check_field("right_pressed", KeyWidth'(want.right),
                           KeyWidth'(rsp_right_pressed));
            end
            reports_seen++;
            if (reports_seen == 30 || reports_seen == 220) hold_left = LongHoldCycles;
         end
         // Hold off through a long stretch, else stall now and then
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet_phase && ($urandom_range(99) < IdlePercent);
         end
      end
   end

   // Give up on a hung run
   int unsigned cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      km_setting_type set;
      tracked_setting = DefaultSetting;
      track_source    = 1'b0;
      clear_tracking('0);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset values, then the edge setting
      apply_setting(DefaultSetting);
      foreach (default_rows[i])
         send_sample(default_rows[i].sample, default_rows[i].typed, default_rows[i].want);
      wait_drained();
      apply_setting(EdgeSetting);
      foreach (edge_rows[i])
         send_sample(edge_rows[i].sample, edge_rows[i].typed, edge_rows[i].want);

      // Random part, one setting per phase; start half of them just before the wrap
      for (int unsigned p = 0; p < NumPhases; p++) begin
         wait_drained();
         set = phase_settings[p];
         if (p == 3 || p == 5) begin
            set.middle_code    = CodeWidth'($urandom_range(3, 1));
            set.launcher_bit   = BitWidth'($urandom_range(15));
            set.shot_bit       = BitWidth'($urandom_range(15));
            set.bypass_bit     = BitWidth'($urandom_range(15));
            set.debounce_ms    = DebWidth'($urandom_range(100));
            set.vision_hold_ms = HoldWidth'($urandom_range(2000));
         end
         apply_setting(set);
         quiet_phase <= (p == QuietPhase);
         stim_tick = (p % 2 == 1) ? 32'hFFFF_FFFF - $urandom_range(30000)
                                  : TimeWidth'($urandom_range(1000));
         run_random_phase(PhaseItems);
      end

      wait_drained();
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/kmdt_pkg.sv
sv/kmdt_deb_lane.sv
sv/keymouse_debounce_toggle_modes.sv
sim/keymouse_debounce_toggle_modes_tb.sv
